// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the segment/box test.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Condition that must hold at every clock edge outside reset.
`define SBIT_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("%m: check failed");
// Antecedent implies consequent at the following edge.
`define SBIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`endif

// File: rtl/sbit_pkg.sv
// Package for the segment/box intersection test: defaults, edge codes, control type.
// No dependencies.
`default_nettype none
package sbit_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int NUM_EDGES       = 4;

	// Clip edges in processing order.
	localparam int EDGE_LEFT   = 0;
	localparam int EDGE_RIGHT  = 1;
	localparam int EDGE_BOTTOM = 2;
	localparam int EDGE_TOP    = 3;

	typedef struct packed {
		logic valid;
		logic done;
		logic hit;
	} ctrl_t;
endpackage
`default_nettype wire

// File: rtl/sbit_if.sv
// Stream interfaces: segment/box input beats and hit result beats.
// Depends on nothing; widths come from the parameter.
`default_nettype none
interface sbit_seg_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] seg_start_x;
	logic signed [W-1:0] seg_start_y;
	logic signed [W-1:0] seg_end_x;
	logic signed [W-1:0] seg_end_y;
	logic signed [W-1:0] box_min_x;
	logic signed [W-1:0] box_min_y;
	logic signed [W-1:0] box_max_x;
	logic signed [W-1:0] box_max_y;
	modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		box_min_x, box_min_y, box_max_x, box_max_y, input ready);
	modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		box_min_x, box_min_y, box_max_x, box_max_y, output ready);
endinterface

interface sbit_hit_if;
	logic valid;
	logic ready;
	logic hit;
	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

// File: rtl/sbit_front.sv
// Front end: normalizes the box, tests both endpoints, forms the clip terms p and q.
// Depends on sbit_pkg.
`default_nettype none
module sbit_front #(
	parameter int W = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic signed [W-1:0]    sx,
	input  wire logic signed [W-1:0]    sy,
	input  wire logic signed [W-1:0]    ex,
	input  wire logic signed [W-1:0]    ey,
	input  wire logic signed [W-1:0]    ax,
	input  wire logic signed [W-1:0]    ay,
	input  wire logic signed [W-1:0]    bx,
	input  wire logic signed [W-1:0]    by,
	output sbit_pkg::ctrl_t             ctrl,
	output logic [W:0]                  n0,
	output logic [W:0]                  d0,
	output logic [W:0]                  n1,
	output logic [W:0]                  d1,
	output logic [sbit_pkg::NUM_EDGES-1:0][W:0] pm,
	output logic [sbit_pkg::NUM_EDGES-1:0]      pn,
	output logic [sbit_pkg::NUM_EDGES-1:0][W:0] qm,
	output logic [sbit_pkg::NUM_EDGES-1:0]      qn
);
	import sbit_pkg::*;
	localparam int M = W + 1;

	logic                valid_s1;
	logic signed [W-1:0] sx_s1, sy_s1, ex_s1, ey_s1, lox_s1, loy_s1, hix_s1, hiy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1  <= sx;
			sy_s1  <= sy;
			ex_s1  <= ex;
			ey_s1  <= ey;
			lox_s1 <= (ax < bx) ? ax : bx;
			hix_s1 <= (ax < bx) ? bx : ax;
			loy_s1 <= (ay < by) ? ay : by;
			hiy_s1 <= (ay < by) ? by : ay;
		end
	end

	function automatic logic signed [M-1:0] sub_ext(logic signed [W-1:0] a,
		logic signed [W-1:0] b);
		return $signed({a[W-1], a}) - $signed({b[W-1], b});
	endfunction

	function automatic logic [M-1:0] mag(logic signed [M-1:0] d);
		return d[M-1] ? M'(-d) : M'(d);
	endfunction

	logic                in_box;
	logic signed [M-1:0] dx, dy;
	logic signed [NUM_EDGES-1:0][M-1:0] qd;

	always_comb begin
		in_box = (sx_s1 >= lox_s1 && sx_s1 <= hix_s1 && sy_s1 >= loy_s1 && sy_s1 <= hiy_s1)
			|| (ex_s1 >= lox_s1 && ex_s1 <= hix_s1 && ey_s1 >= loy_s1 && ey_s1 <= hiy_s1);
		dx = sub_ext(ex_s1, sx_s1);
		dy = sub_ext(ey_s1, sy_s1);
		qd[EDGE_LEFT]   = sub_ext(sx_s1, lox_s1);
		qd[EDGE_RIGHT]  = sub_ext(hix_s1, sx_s1);
		qd[EDGE_BOTTOM] = sub_ext(sy_s1, loy_s1);
		qd[EDGE_TOP]    = sub_ext(hiy_s1, sy_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl <= '0;
		end else if (en) begin
			ctrl.valid <= valid_s1;
			ctrl.done  <= in_box;
			ctrl.hit   <= in_box;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n0 <= '0;
			d0 <= M'(1);
			n1 <= M'(1);
			d1 <= M'(1);
			pm[EDGE_LEFT]   <= mag(dx);
			pn[EDGE_LEFT]   <= !dx[M-1];
			pm[EDGE_RIGHT]  <= mag(dx);
			pn[EDGE_RIGHT]  <= dx[M-1];
			pm[EDGE_BOTTOM] <= mag(dy);
			pn[EDGE_BOTTOM] <= !dy[M-1];
			pm[EDGE_TOP]    <= mag(dy);
			pn[EDGE_TOP]    <= dy[M-1];
			for (int i = 0; i < NUM_EDGES; i++) begin
				qm[i] <= mag(qd[i]);
				qn[i] <= qd[i][M-1];
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/sbit_cell.sv
// One clip cell: narrows [t0,t1] against one box edge over two stages.
// Products are registered in the first stage; the second compares and updates.
// Depends on sbit_pkg.
`default_nettype none
module sbit_cell #(
	parameter int W    = 32,
	parameter int EDGE = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire sbit_pkg::ctrl_t        ctrl_i,
	input  wire logic [W:0]             n0_i,
	input  wire logic [W:0]             d0_i,
	input  wire logic [W:0]             n1_i,
	input  wire logic [W:0]             d1_i,
	input  wire logic [sbit_pkg::NUM_EDGES-1:0][W:0] pm_i,
	input  wire logic [sbit_pkg::NUM_EDGES-1:0]      pn_i,
	input  wire logic [sbit_pkg::NUM_EDGES-1:0][W:0] qm_i,
	input  wire logic [sbit_pkg::NUM_EDGES-1:0]      qn_i,
	output sbit_pkg::ctrl_t             ctrl_o,
	output logic [W:0]                  n0_o,
	output logic [W:0]                  d0_o,
	output logic [W:0]                  n1_o,
	output logic [W:0]                  d1_o,
	output logic [sbit_pkg::NUM_EDGES-1:0][W:0] pm_o,
	output logic [sbit_pkg::NUM_EDGES-1:0]      pn_o,
	output logic [sbit_pkg::NUM_EDGES-1:0][W:0] qm_o,
	output logic [sbit_pkg::NUM_EDGES-1:0]      qn_o
);
	import sbit_pkg::*;
	localparam int M = W + 1;

	ctrl_t        ctrl_s1;
	logic [M-1:0] n0_s1, d0_s1, n1_s1, d1_s1;
	logic [NUM_EDGES-1:0][M-1:0] pm_s1, qm_s1;
	logic [NUM_EDGES-1:0]        pn_s1, qn_s1;
	// q*d0, n0*p, q*d1, n1*p for this edge
	logic [2*M-1:0] qd0_s1, n0p_s1, qd1_s1, n1p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n0_s1  <= n0_i;
			d0_s1  <= d0_i;
			n1_s1  <= n1_i;
			d1_s1  <= d1_i;
			pm_s1  <= pm_i;
			pn_s1  <= pn_i;
			qm_s1  <= qm_i;
			qn_s1  <= qn_i;
			qd0_s1 <= qm_i[EDGE] * d0_i;
			n0p_s1 <= n0_i * pm_i[EDGE];
			qd1_s1 <= qm_i[EDGE] * d1_i;
			n1p_s1 <= n1_i * pm_i[EDGE];
		end
	end

	ctrl_t        ctrl_nx;
	logic [M-1:0] n0_nx, d0_nx, n1_nx, d1_nx;
	logic         r_neg;

	always_comb begin
		ctrl_nx = ctrl_s1;
		n0_nx   = n0_s1;
		d0_nx   = d0_s1;
		n1_nx   = n1_s1;
		d1_nx   = d1_s1;
		r_neg   = (qn_s1[EDGE] != pn_s1[EDGE]) && (qm_s1[EDGE] != '0);
		if (!ctrl_s1.done) begin
			if (pm_s1[EDGE] == '0) begin
				// Parallel to this edge: outside it is a miss, otherwise no constraint.
				if (qn_s1[EDGE] && qm_s1[EDGE] != '0) begin
					ctrl_nx.done = 1'b1;
					ctrl_nx.hit  = 1'b0;
				end
			end else if (pn_s1[EDGE]) begin
				// Entering edge; t0 and t1 are never negative, so a negative ratio is moot.
				if (!r_neg) begin
					if (qd1_s1 > n1p_s1) begin
						ctrl_nx.done = 1'b1;
						ctrl_nx.hit  = 1'b0;
					end else if (qd0_s1 > n0p_s1) begin
						n0_nx = qm_s1[EDGE];
						d0_nx = pm_s1[EDGE];
					end
				end
			end else begin
				if (r_neg || qd0_s1 < n0p_s1) begin
					ctrl_nx.done = 1'b1;
					ctrl_nx.hit  = 1'b0;
				end else if (qd1_s1 < n1p_s1) begin
					n1_nx = qm_s1[EDGE];
					d1_nx = pm_s1[EDGE];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else if (en) begin
			ctrl_o <= ctrl_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n0_o <= n0_nx;
			d0_o <= d0_nx;
			n1_o <= n1_nx;
			d1_o <= d1_nx;
			pm_o <= pm_s1;
			pn_o <= pn_s1;
			qm_o <= qm_s1;
			qn_o <= qn_s1;
		end
	end
endmodule
`default_nettype wire

// File: rtl/segment_box_intersection_test_top.sv
// Top level of the segment versus axis-aligned box touch test.
// Depends on sbit_pkg, sbit_if, sbit_front and sbit_cell.
`default_nettype none
// One beat in, one hit beat out, one beat per cycle while the output is not stalled.
// The pipeline has two front stages (box normalization, endpoint tests and clip terms),
// then a chain of four clip cells, one per box edge, each with a multiply stage
// and a compare stage. The whole pipeline advances whenever the output register
// is empty or being taken, so input ready follows output ready.
module segment_box_intersection_test_top #(
	parameter int COORD_WIDTH = sbit_pkg::COORD_WIDTH_DEF
) (
	input wire logic         clk,
	input wire logic         arst_n,
	sbit_seg_if.sink         seg_in,
	sbit_hit_if.source       hit_out
);
	import sbit_pkg::*;
	localparam int M = COORD_WIDTH + 1;

	ctrl_t                       ctrl  [NUM_EDGES+1];
	logic [M-1:0]                n0    [NUM_EDGES+1];
	logic [M-1:0]                d0    [NUM_EDGES+1];
	logic [M-1:0]                n1    [NUM_EDGES+1];
	logic [M-1:0]                d1    [NUM_EDGES+1];
	logic [NUM_EDGES-1:0][M-1:0] pm    [NUM_EDGES+1];
	logic [NUM_EDGES-1:0]        pn    [NUM_EDGES+1];
	logic [NUM_EDGES-1:0][M-1:0] qm    [NUM_EDGES+1];
	logic [NUM_EDGES-1:0]        qn    [NUM_EDGES+1];
	logic                        en;

	assign en            = !ctrl[NUM_EDGES].valid || hit_out.ready;
	assign seg_in.ready  = en;
	assign hit_out.valid = ctrl[NUM_EDGES].valid;
	// A beat that survives every box edge is a hit.
	assign hit_out.hit   = ctrl[NUM_EDGES].done ? ctrl[NUM_EDGES].hit : 1'b1;

	sbit_front #(.W(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(seg_in.valid),
		.sx(seg_in.seg_start_x), .sy(seg_in.seg_start_y),
		.ex(seg_in.seg_end_x), .ey(seg_in.seg_end_y),
		.ax(seg_in.box_min_x), .ay(seg_in.box_min_y),
		.bx(seg_in.box_max_x), .by(seg_in.box_max_y),
		.ctrl(ctrl[0]), .n0(n0[0]), .d0(d0[0]), .n1(n1[0]), .d1(d1[0]),
		.pm(pm[0]), .pn(pn[0]), .qm(qm[0]), .qn(qn[0])
	);

	for (genvar g = 0; g < NUM_EDGES; g++) begin : g_cell
		sbit_cell #(.W(COORD_WIDTH), .EDGE(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.ctrl_i(ctrl[g]), .n0_i(n0[g]), .d0_i(d0[g]), .n1_i(n1[g]), .d1_i(d1[g]),
			.pm_i(pm[g]), .pn_i(pn[g]), .qm_i(qm[g]), .qn_i(qn[g]),
			.ctrl_o(ctrl[g+1]), .n0_o(n0[g+1]), .d0_o(d0[g+1]), .n1_o(n1[g+1]),
			.d1_o(d1[g+1]), .pm_o(pm[g+1]), .pn_o(pn[g+1]), .qm_o(qm[g+1]),
			.qn_o(qn[g+1])
		);
	end
endmodule
`default_nettype wire

// File: rtl/sbit_checker.sv
// Port-level checks for the segment/box test top level, attached by bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sbit_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_hit
);
	// A stalled result beat holds.
	`SBIT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_hit))
	// The pipeline only refuses input when a result is held.
	`SBIT_ASSERT(a_ready_stall, clk, arst_n, in_ready || (out_valid && !out_ready))
	// A taken output never blocks the input side.
	`SBIT_ASSERT(a_ready_follow, clk, arst_n, !out_ready || in_ready)
	// The pipeline comes out of reset empty.
	`SBIT_ASSERT(a_reset_idle, clk, arst_n, $past(arst_n) || !out_valid)
endmodule

bind segment_box_intersection_test_top sbit_checker u_sbit_checker (
	.clk(clk), .arst_n(arst_n),
	.in_ready(seg_in.ready),
	.out_valid(hit_out.valid), .out_ready(hit_out.ready), .out_hit(hit_out.hit)
);
`default_nettype wire
